// ===== sv/sscan_pkg.sv =====
// Shared types, constants and the palette lookup of the screen scan block.
package sscan_pkg;

  // Screen geometry and store depths.
  localparam int ActiveWidth  = 256;
  localparam int ActiveHeight = 192;
  localparam int CellsAcross  = ActiveWidth / 8;
  localparam int BitmapDepth  = ActiveWidth * ActiveHeight / 8;
  localparam int AttrDepth    = CellsAcross * (ActiveHeight / 8);

  localparam int AddrW   = 13;
  localparam int AttrAW  = 10;
  localparam int CoordW  = 8;
  localparam int ColourW = 4;

  // Work carried from the front to the back.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_BITMAP_WR,
    OP_ATTR_WR,
    OP_RENDER
  } sscan_op_e;

  // One queued word: a store write or a render at a fixed scan position.
  typedef struct packed {
    sscan_op_e           op;
    logic [AddrW-1:0]    baddr;
    logic [AttrAW-1:0]   aaddr;
    logic [7:0]          wdata;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic                phase;
  } sscan_entry_t;

  // Two sixteen-entry palettes, packed as {red, green, blue}.
  function automatic logic [23:0] sscan_palette(input logic sel,
                                                input logic [ColourW-1:0] idx);
    logic [23:0] rgb;
    unique case ({sel, idx})
      5'd0:  rgb = 24'h000000;
      5'd1:  rgb = 24'h0000C0;
      5'd2:  rgb = 24'hC00000;
      5'd3:  rgb = 24'hC000C0;
      5'd4:  rgb = 24'h00C000;
      5'd5:  rgb = 24'h00C0C0;
      5'd6:  rgb = 24'hC0C000;
      5'd7:  rgb = 24'hC0C0C0;
      5'd8:  rgb = 24'h000000;
      5'd9:  rgb = 24'h6060FF;
      5'd10: rgb = 24'hFF6060;
      5'd11: rgb = 24'hFF60FF;
      5'd12: rgb = 24'h60FF60;
      5'd13: rgb = 24'h60FFFF;
      5'd14: rgb = 24'hFFFF60;
      5'd15: rgb = 24'hFFFFFF;
      5'd16: rgb = 24'h000000;
      5'd17: rgb = 24'h60609F;
      5'd18: rgb = 24'h9F6060;
      5'd19: rgb = 24'h9F609F;
      5'd20: rgb = 24'h609F60;
      5'd21: rgb = 24'h609F9F;
      5'd22: rgb = 24'h9F9F60;
      5'd23: rgb = 24'h606060;
      5'd24: rgb = 24'h000000;
      5'd25: rgb = 24'h9F9FFF;
      5'd26: rgb = 24'hFD9F9F;
      5'd27: rgb = 24'hFF9FFF;
      5'd28: rgb = 24'h9FFF9F;
      5'd29: rgb = 24'h9FFFFF;
      5'd30: rgb = 24'hFFFF9F;
      5'd31: rgb = 24'h9F9F9F;
    endcase
    return rgb;
  endfunction

endpackage

// ===== sv/sscan_front.sv =====
// Front end: accepts input words, classifies them and tracks the scan position.
module sscan_front import sscan_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                command_i,
  input  logic [AddrW-1:0]    address_i,
  input  logic [7:0]          write_data_i,
  input  logic                flash_phase_i,
  output logic                push_o,
  output sscan_entry_t        entry_o
);

  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;
  logic              col_last;
  logic              row_last;
  logic [AddrW-1:0]  attr_off;

  assign col_last = (col_q == CoordW'(ActiveWidth - 1));
  assign row_last = (row_q == CoordW'(ActiveHeight - 1));
  assign attr_off = address_i - AddrW'(BitmapDepth);

  // Classify the word and build the queue entry.
  always_comb begin
    entry_o.wdata = write_data_i;
    entry_o.x     = col_q;
    entry_o.y     = row_q;
    entry_o.phase = flash_phase_i;
    if (command_i) begin
      entry_o.op    = OP_RENDER;
      // Native layout: row bits 2..0 and 5..3 trade places.
      entry_o.baddr = {row_q[7:6], row_q[2:0], row_q[5:3], col_q[7:3]};
      entry_o.aaddr = {row_q[7:3], col_q[7:3]};
    end else begin
      entry_o.baddr = address_i;
      entry_o.aaddr = attr_off[AttrAW-1:0];
      if (address_i < AddrW'(BitmapDepth)) begin
        entry_o.op = OP_BITMAP_WR;
      end else if (address_i < AddrW'(BitmapDepth + AttrDepth)) begin
        entry_o.op = OP_ATTR_WR;
      end else begin
        entry_o.op = OP_NONE;
      end
    end
  end

  // Writes past the attribute area are dropped here.
  assign push_o = accept_i && (entry_o.op != OP_NONE);

  // Raster scan position, advanced by every accepted render.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i && command_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== sv/sscan_queue.sv =====
// Short queue of words between the front end and the back end.
module sscan_queue import sscan_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sscan_entry_t  entry_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          stall_i,
  output sscan_entry_t  entry_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  sscan_entry_t    slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/sscan_back.sv =====
// Back end: screen memories, pixel colouring and the output register.
module sscan_back import sscan_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                q_valid_i,
  output logic                q_stall_o,
  input  sscan_entry_t        entry_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CoordW-1:0]   pixel_x_o,
  output logic [CoordW-1:0]   pixel_y_o,
  output logic [ColourW-1:0]  colour_index_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic                frame_end_o
);

  logic [7:0]         bitmap_mem [BitmapDepth];
  logic [7:0]         attr_mem [AttrDepth];

  logic               palette_q;
  logic               s1_valid_q;
  logic [7:0]         bits_q;
  logic [7:0]         attr_q;
  logic [CoordW-1:0]  s1_x_q;
  logic [CoordW-1:0]  s1_y_q;
  logic               s1_phase_q;
  logic               out_valid_q;

  logic               s1_adv;
  logic               pop;
  logic               pop_render;
  logic               pix;
  logic               show_ink;
  logic [ColourW-1:0] idx;
  logic [23:0]        rgb;

  // Stage hand-off: a word leaves the queue when the read stage can free up.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign q_stall_o  = s1_valid_q && !s1_adv;
  assign pop        = q_valid_i && !q_stall_o;
  assign pop_render = pop && (entry_i.op == OP_RENDER);

  // Palette register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= 1'b0;
    end else if (cfg_we_i) begin
      palette_q <= cfg_wdata_i;
    end
  end

  // Bitmap memory: one write or one registered read per word.
  always_ff @(posedge clk_i) begin
    if (pop && entry_i.op == OP_BITMAP_WR) begin
      bitmap_mem[entry_i.baddr] <= entry_i.wdata;
    end
    if (pop_render) begin
      bits_q <= bitmap_mem[entry_i.baddr];
    end
  end

  // Attribute memory: one write or one registered read per word.
  always_ff @(posedge clk_i) begin
    if (pop && entry_i.op == OP_ATTR_WR) begin
      attr_mem[entry_i.aaddr] <= entry_i.wdata;
    end
    if (pop_render) begin
      attr_q <= attr_mem[entry_i.aaddr];
    end
  end

  // Scan position travels alongside the memory read.
  always_ff @(posedge clk_i) begin
    if (pop_render) begin
      s1_x_q     <= entry_i.x;
      s1_y_q     <= entry_i.y;
      s1_phase_q <= entry_i.phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pop_render) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Pick the pixel bit, apply flash and choose ink or paper.
  // Attribute byte: flash, bright, paper[2:0], ink[2:0].
  always_comb begin
    pix      = bits_q[~s1_x_q[2:0]];
    show_ink = pix ^ (attr_q[7] & s1_phase_q);
    idx      = show_ink ? {attr_q[6], attr_q[2:0]} : {1'b0, attr_q[5:3]};
    rgb      = sscan_palette(palette_q, idx);
  end

  // Output register, loaded whenever the read stage moves on.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_x_o      <= s1_x_q;
      pixel_y_o      <= s1_y_q;
      colour_index_o <= idx;
      red_o          <= rgb[23:16];
      green_o        <= rgb[15:8];
      blue_o         <= rgb[7:0];
      frame_end_o    <= (s1_x_q == CoordW'(ActiveWidth - 1)) &&
                        (s1_y_q == CoordW'(ActiveHeight - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/spectrum_screen_scan_core.sv =====
// Top level of the screen memory and raster scan block.
//
// The block takes one word per clock while its queue has room and delivers
// one pixel word per clock while the output side does not stall: each word
// makes a single access to the bitmap and attribute memories in the back end,
// and that one access per word sets the rate of one word per cycle. A render
// word is written into the queue at the clock edge that accepts it and then
// passes the memory read and the output register before it shows up at the
// output; write words and writes beyond the attribute area give no output.
// The screen memories are not cleared after reset and need no clearing pass,
// so the block takes words as soon as reset is released.
module spectrum_screen_scan_core import sscan_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [AddrW-1:0]    address_i,
  input  logic [7:0]          write_data_i,
  input  logic                flash_phase_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CoordW-1:0]   pixel_x_o,
  output logic [CoordW-1:0]   pixel_y_o,
  output logic [ColourW-1:0]  colour_index_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic                frame_end_o
);

  logic         accept;
  logic         push;
  logic         full;
  logic         q_valid;
  logic         q_stall;
  sscan_entry_t front_entry;
  sscan_entry_t back_entry;

  // A word is taken whenever the queue has a free slot.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sscan_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .flash_phase_i (flash_phase_i),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  sscan_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .stall_i (q_stall),
    .entry_o (back_entry)
  );

  sscan_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_stall_o      (q_stall),
    .entry_i        (back_entry),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .colour_index_o (colour_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

// ===== sv/sscan_checker.sv =====
// Port-level checks of the screen scan block and their binding to the top level.
module sscan_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] pixel_x_o,
  input logic [7:0] pixel_y_o,
  input logic [3:0] colour_index_o,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic       frame_end_o
);

  // A stalled output word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(colour_index_o) && $stable(red_o))
    else $error("stalled output word changed");

  // Frame end marks exactly the bottom right pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == ((pixel_x_o == 8'd255) && (pixel_y_o == 8'd191))))
    else $error("frame end flag does not match the pixel position");

  // Rows never run past the active area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_y_o <= 8'd191))
    else $error("pixel row outside the active area");

  // Both black entries are black in either palette.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((colour_index_o == 4'd0) || (colour_index_o == 4'd8)) |->
      (red_o == 8'd0) && (green_o == 8'd0) && (blue_o == 8'd0))
    else $error("black palette entry gave a colour");

endmodule

bind spectrum_screen_scan_core sscan_checker u_sscan_checker (.*);

// ===== verif/spectrum_screen_scan_core_tb.sv =====
// Self-checking testbench of the screen memory and raster scan block.
module spectrum_screen_scan_core_tb;
  import sscan_pkg::*;

  // Command codes of the input word.
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdRender = 1'b1;

  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 300;
  localparam int QuietLimit   = 5000;
  localparam int IdlePct      = 18;

  // Palettes packed with entry 15 in the top bits, {red, green, blue} each.
  localparam logic [16*24-1:0] NormalRgb = {
    24'hFFFFFF, 24'hFFFF60, 24'h60FFFF, 24'h60FF60,
    24'hFF60FF, 24'hFF6060, 24'h6060FF, 24'h000000,
    24'hC0C0C0, 24'hC0C000, 24'h00C0C0, 24'h00C000,
    24'hC000C0, 24'hC00000, 24'h0000C0, 24'h000000};
  localparam logic [16*24-1:0] MutedRgb = {
    24'h9F9F9F, 24'hFFFF9F, 24'h9FFFFF, 24'h9FFF9F,
    24'hFF9FFF, 24'hFD9F9F, 24'h9F9FFF, 24'h000000,
    24'h606060, 24'h9F9F60, 24'h609F9F, 24'h609F60,
    24'h9F609F, 24'h9F6060, 24'h60609F, 24'h000000};

  typedef struct packed {
    logic             cmd;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic             phase;
  } screen_word_t;

  typedef struct packed {
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [ColourW-1:0] idx;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               fe;
  } pixel_word_t;

  typedef struct {
    screen_word_t w;
    bit           typed;
    pixel_word_t  pix;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                command_i = 1'b0;
  logic [AddrW-1:0]    address_i = '0;
  logic [7:0]          write_data_i = '0;
  logic                flash_phase_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CoordW-1:0]   pixel_x_o;
  logic [CoordW-1:0]   pixel_y_o;
  logic [ColourW-1:0]  colour_index_o;
  logic [7:0]          red_o;
  logic [7:0]          green_o;
  logic [7:0]          blue_o;
  logic                frame_end_o;

  spectrum_screen_scan_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .flash_phase_i  (flash_phase_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .colour_index_o (colour_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the screen, the scan position and the palette register.
  logic [7:0]        shadow_bitmap [BitmapDepth];
  logic [7:0]        shadow_attr [AttrDepth];
  bit                bitmap_seen [BitmapDepth];
  bit                attr_seen [AttrDepth];
  logic [CoordW-1:0] shadow_col = '0;
  logic [CoordW-1:0] shadow_row = '0;
  logic              shadow_palette = 1'b0;

  pixel_word_t pending_pixels [$];
  stim_row_t   directed_rows [$];

  int in_idle_pct = IdlePct;
  int out_stall_pct = IdlePct;
  bit hold_req = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int n_writes = 0;
  int n_pixels = 0;

  // Native bitmap address: the two 3-bit row fields of the linear offset swap places.
  function automatic logic [AddrW-1:0] bitmap_index(logic [7:0] col, logic [7:0] row);
    logic [AddrW-1:0] lin;
    lin = AddrW'(int'(row) * CellsAcross + int'(col[7:3]));
    return {lin[12:11], lin[7:5], lin[10:8], lin[4:0]};
  endfunction

  function automatic logic [AttrAW-1:0] cell_index(logic [7:0] col, logic [7:0] row);
    return AttrAW'(int'(row[7:3]) * CellsAcross + int'(col[7:3]));
  endfunction

  // Apply one accepted word to the shadow screen and queue the pixel it yields.
  task automatic commit_word(input screen_word_t w, input bit typed,
                             input pixel_word_t typed_pix);
    logic [AddrW-1:0]  baddr;
    logic [AttrAW-1:0] cell_idx;
    logic [7:0]        bits;
    logic [7:0]        attr;
    logic              lit;
    pixel_word_t       pix;
    if (w.cmd == CmdWrite) begin
      n_writes++;
      if (w.addr < BitmapDepth) begin
        shadow_bitmap[w.addr] = w.data;
        bitmap_seen[w.addr] = 1'b1;
      end else if (w.addr < BitmapDepth + AttrDepth) begin
        shadow_attr[AttrAW'(w.addr - BitmapDepth)] = w.data;
        attr_seen[AttrAW'(w.addr - BitmapDepth)] = 1'b1;
      end
    end else begin
      baddr = bitmap_index(shadow_col, shadow_row);
      cell_idx = cell_index(shadow_col, shadow_row);
      bits = shadow_bitmap[baddr];
      attr = shadow_attr[cell_idx];
      lit = bits[3'd7 - shadow_col[2:0]] ^ (attr[7] & w.phase);
      pix.x = shadow_col;
      pix.y = shadow_row;
      pix.idx = lit ? {attr[6], attr[2:0]} : {1'b0, attr[5:3]};
      {pix.red, pix.green, pix.blue} = shadow_palette ? MutedRgb[int'(pix.idx)*24 +: 24]
                                                      : NormalRgb[int'(pix.idx)*24 +: 24];
      pix.fe = (shadow_col == ActiveWidth - 1) && (shadow_row == ActiveHeight - 1);
      // Raster advance with wrap at the end of the line and of the frame.
      if (shadow_col == ActiveWidth - 1) begin
        shadow_col = '0;
        shadow_row = (shadow_row == ActiveHeight - 1) ? '0 : shadow_row + 1'b1;
      end else begin
        shadow_col = shadow_col + 1'b1;
      end
      pending_pixels.push_back(typed ? typed_pix : pix);
    end
  endtask

  // Offer one word after a random idle gap and hold it until it is taken.
  task automatic send_word(input screen_word_t w, input bit typed, input pixel_word_t pix);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= w.cmd;
    address_i     <= w.addr;
    write_data_i  <= w.data;
    flash_phase_i <= w.phase;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    commit_word(w, typed, pix);
  endtask

  // Random word; a render goes out only once both bytes under the scan are written.
  task automatic random_word(input int render_pct);
    screen_word_t      w;
    logic [AddrW-1:0]  baddr;
    logic [AttrAW-1:0] cell_idx;
    w.addr  = AddrW'($urandom_range(0, 8191));
    w.data  = 8'($urandom_range(0, 255));
    w.phase = 1'($urandom_range(0, 1));
    baddr = bitmap_index(shadow_col, shadow_row);
    cell_idx = cell_index(shadow_col, shadow_row);
    if ($urandom_range(99) < render_pct) begin
      w.cmd = CmdWrite;
      if (!bitmap_seen[baddr]) w.addr = baddr;
      else if (!attr_seen[cell_idx]) w.addr = AddrW'(BitmapDepth + cell_idx);
      else w.cmd = CmdRender;
    end else begin
      w.cmd = CmdWrite;
      // Some writes land on the cell under the scan so that it changes mid-byte.
      case ($urandom_range(5))
        0: w.addr = baddr;
        1: w.addr = AddrW'(BitmapDepth + cell_idx);
        default: ;
      endcase
    end
    send_word(w, 1'b0, '0);
  endtask

  // Wait until every pixel has arrived and trailing writes have left the pipe.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_palette(input logic sel);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sel;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_palette = sel;
  endtask

  task automatic add_row(input logic cmd, input int addr, input int data, input logic phase,
                         input bit typed, input pixel_word_t pix);
    stim_row_t row;
    row.w.cmd   = cmd;
    row.w.addr  = AddrW'(addr);
    row.w.data  = 8'(data);
    row.w.phase = phase;
    row.typed   = typed;
    row.pix     = pix;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned got);
    if (expv != got) begin
      $error("%s: expected %0d, got %0d", name, expv, got);
      mismatch_count++;
    end
  endtask

  // Output side: random stalls plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // Watchdog on handshake progress, and the check of every accepted pixel word.
  always @(posedge clk_i) begin
    pixel_word_t want;
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d pixels outstanding",
               QuietLimit, pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel word at (%0d,%0d) with none expected", pixel_x_o, pixel_y_o);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        n_pixels++;
        check_field("pixel_x", 32'(want.x), 32'(pixel_x_o));
        check_field("pixel_y", 32'(want.y), 32'(pixel_y_o));
        check_field("colour_index", 32'(want.idx), 32'(colour_index_o));
        check_field("red", 32'(want.red), 32'(red_o));
        check_field("green", 32'(want.green), 32'(green_o));
        check_field("blue", 32'(want.blue), 32'(blue_o));
        check_field("frame_end", 32'(want.fe), 32'(frame_end_o));
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset palette; renders carry ignored address and data.
    add_row(CmdWrite,  0,    8'h80, 1'b0, 1'b0, '0);
    add_row(CmdWrite,  6144, 8'h47, 1'b0, 1'b0, '0);
    add_row(CmdRender, 8191, 8'hFF, 1'b0, 1'b1, {8'd0, 8'd0, 4'd15, 24'hFFFFFF, 1'b0});
    add_row(CmdRender, 8191, 8'hFF, 1'b1, 1'b1, {8'd1, 8'd0, 4'd0, 24'h000000, 1'b0});
    add_row(CmdWrite,  6144, 8'hFF, 1'b1, 1'b0, '0);
    add_row(CmdRender, 0,    8'h00, 1'b0, 1'b0, '0);
    add_row(CmdRender, 0,    8'h00, 1'b1, 1'b0, '0);
    add_row(CmdWrite,  0,    8'hFF, 1'b0, 1'b0, '0);
    add_row(CmdRender, 6911, 8'h55, 1'b1, 1'b0, '0);
    add_row(CmdRender, 6911, 8'hAA, 1'b0, 1'b0, '0);
    // Writes past the attribute area must leave the first cell untouched.
    add_row(CmdWrite,  8191, 8'h00, 1'b1, 1'b0, '0);
    add_row(CmdWrite,  6912, 8'h00, 1'b0, 1'b0, '0);
    add_row(CmdRender, 4096, 8'h0F, 1'b0, 1'b0, '0);
    add_row(CmdWrite,  6143, 8'hAA, 1'b0, 1'b0, '0);
    add_row(CmdWrite,  6911, 8'h38, 1'b1, 1'b0, '0);
    add_row(CmdWrite,  0,    8'h00, 1'b0, 1'b0, '0);
    add_row(CmdRender, 0,    8'h00, 1'b1, 1'b0, '0);
    add_row(CmdWrite,  1,    8'h55, 1'b0, 1'b0, '0);
    add_row(CmdWrite,  6145, 8'h07, 1'b0, 1'b0, '0);
    add_row(CmdRender, 0,    8'h00, 1'b1, 1'b0, '0);
    add_row(CmdRender, 0,    8'h00, 1'b0, 1'b0, '0);
    add_row(CmdWrite,  4096, 8'h00, 1'b1, 1'b0, '0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].pix);
    drain();

    // Random phases across both palette settings.
    write_palette(1'b1);
    repeat (700) random_word(55);
    drain();

    // The output holds off for a long stretch so the input side backs up.
    write_palette(1'b0);
    hold_req = 1'b1;
    repeat (700) random_word(55);
    drain();

    // A stretch with no idling on either side.
    write_palette(1'b1);
    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (600) random_word(55);
    drain();

    // A closing stretch that is mostly renders, back at the normal palette.
    in_idle_pct = IdlePct;
    out_stall_pct = IdlePct;
    write_palette(1'b0);
    repeat (200) random_word(90);
    drain();

    $display("covered %0d screen writes and %0d checked pixels,",
             n_writes, n_pixels);
    $display("both palettes, ignored addresses, flash inversion and a long output hold-off");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sscan_pkg.sv
sv/sscan_front.sv
sv/sscan_queue.sv
sv/sscan_back.sv
sv/spectrum_screen_scan_core.sv
sv/sscan_checker.sv
verif/spectrum_screen_scan_core_tb.sv
